@@ hw/rtl/scharr_gradient_3x3_macros.svh @@
// Assertion macros shared by the Scharr gradient RTL.
// Used by the top level only; no other dependencies.
`ifndef SCHARR_GRADIENT_3X3_MACROS_SVH
`define SCHARR_GRADIENT_3X3_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define SCG_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define SCG_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ hw/rtl/scg_pkg.sv @@
// Package for the Scharr gradient block: field widths, coefficients,
// register indexes and the queue entry types. No dependencies.
package scg_pkg;

  localparam int PIX_W      = 8;
  localparam int GRAD_W     = 17;
  localparam int LW_REG_W   = 12;
  localparam int FH_REG_W   = 13;
  localparam int ROW_W      = 12;
  localparam int HGT_W      = 13;
  localparam int MAX_HEIGHT = 4096;
  localparam int MIN_DIM    = 3;
  localparam int WIDTH_RST  = 640;
  localparam int HEIGHT_RST = 480;

  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 13;
  localparam logic [CFG_IDX_W-1:0] CFG_LINE_WIDTH   = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_FRAME_HEIGHT = 1'b1;

  localparam logic signed [GRAD_W-1:0] K_SIDE = 17'sd47;
  localparam logic signed [GRAD_W-1:0] K_MID  = 17'sd162;

  localparam int Q_DEPTH = 4;
  localparam int Q_PTR_W = 2;
  localparam int Q_CNT_W = 3;
  localparam logic [Q_CNT_W-1:0] Q_FULL = 3'd4;

  // Differences of the window, ready for the coefficient products.
  typedef struct packed {
    logic signed [9:0] dx_sum;  // (top - left top) + (bottom - left bottom)
    logic signed [8:0] dx_mid;  // middle - left middle
    logic signed [9:0] dy_sum;  // (left bottom + bottom) - (left top + top)
    logic signed [8:0] dy_mid;  // center bottom - center top
    logic              frame_done;
  } work_t;

  typedef struct packed {
    logic  valid;
    work_t work;
  } push_t;

  typedef struct packed {
    logic  empty;
    work_t head;
  } q_rd_t;

endpackage

@@ hw/rtl/scg_pix_if.sv @@
// Pixel input channel of the Scharr gradient block.
// Depends on scg_pkg for the pixel width.
interface scg_pix_if import scg_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [PIX_W-1:0] pixel;

  modport source (output valid, output pixel, input ready);
  modport sink (input valid, input pixel, output ready);
endinterface

@@ hw/rtl/scg_grad_if.sv @@
// Gradient result channel of the Scharr gradient block.
// Depends on scg_pkg for the gradient width.
interface scg_grad_if import scg_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic signed [GRAD_W-1:0] grad_x;
  logic signed [GRAD_W-1:0] grad_y;
  logic                     frame_done;

  modport source (output valid, output grad_x, output grad_y, output frame_done, input ready);
  modport sink (input valid, input grad_x, input grad_y, input frame_done, output ready);
endinterface

@@ hw/rtl/scg_cfg_if.sv @@
// Configuration write channel of the Scharr gradient block.
// Depends on scg_pkg for the index and data widths.
interface scg_cfg_if import scg_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

@@ hw/rtl/scg_front.sv @@
// Front end: pixel intake, raster counters, line stores and the 3x3 window.
// Pushes window differences of interior pixels into the queue. Uses scg_pkg.
module scg_front import scg_pkg::*; #(
  parameter int MAX_WIDTH = 2048,
  localparam int COL_W = $clog2(MAX_WIDTH),
  localparam int WID_W = $clog2(MAX_WIDTH + 1)
) (
  input  logic               clk,
  input  logic               rst_n,
  scg_pix_if.sink            in_ch,
  input  logic [WID_W-1:0]   eff_width,
  input  logic [HGT_W-1:0]   eff_height,
  input  logic [Q_CNT_W-1:0] q_count,
  output push_t              q_push
);

  logic [PIX_W-1:0] store_up  [MAX_WIDTH];
  logic [PIX_W-1:0] store_mid [MAX_WIDTH];

  logic [COL_W-1:0] col_r, col_nxt;
  logic [ROW_W-1:0] row_r, row_nxt;

  logic             p1_v_r, p1_emit_r, p1_last_r, p1_row1_r, p1_row2_r;
  logic [COL_W-1:0] p1_addr_r;
  logic [PIX_W-1:0] p1_pix_r, top_rd_r, mid_rd_r;
  logic [PIX_W-1:0] win_r [6];

  logic             accept;
  logic [WID_W-1:0] col_w;
  logic [HGT_W-1:0] row_h;
  logic             emit, last;
  logic [PIX_W-1:0] top_px, mid_px, bot_px;

  // Credits: every item in the read stage may still need a queue slot.
  assign in_ch.ready = (q_count + Q_CNT_W'(p1_v_r)) < Q_FULL;
  assign accept      = in_ch.valid && in_ch.ready;

  assign col_w = WID_W'(col_r);
  assign row_h = HGT_W'(row_r);
  assign emit  = (row_r >= ROW_W'(2)) && (col_r >= COL_W'(2)) &&
                 (col_w < eff_width) && (row_h < eff_height);
  assign last  = (row_h == eff_height - HGT_W'(1)) && (col_w == eff_width - WID_W'(1));

  always_comb begin
    col_nxt = col_r;
    row_nxt = row_r;
    if (col_w + WID_W'(1) >= eff_width) begin
      col_nxt = '0;
      row_nxt = (row_h + HGT_W'(1) >= eff_height) ? '0 : row_r + ROW_W'(1);
    end else begin
      col_nxt = col_r + COL_W'(1);
      if (row_h >= eff_height) begin
        row_nxt = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r  <= '0;
      row_r  <= '0;
      p1_v_r <= 1'b0;
    end else begin
      p1_v_r <= accept;
      if (accept) begin
        col_r <= col_nxt;
        row_r <= row_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      p1_emit_r <= emit;
      p1_last_r <= last;
      p1_row1_r <= row_r >= ROW_W'(1);
      p1_row2_r <= row_r >= ROW_W'(2);
      p1_addr_r <= col_r;
      p1_pix_r  <= in_ch.pixel;
    end
  end

  // The middle store is read and rewritten by the same transfer; the read sees the old row.
  always_ff @(posedge clk) begin
    if (accept) begin
      mid_rd_r            <= store_mid[col_r];
      store_mid[col_r]    <= in_ch.pixel;
    end
  end

  // The upper store takes the middle row in the next cycle, once its read data is back.
  always_ff @(posedge clk) begin
    if (accept) begin
      top_rd_r <= store_up[col_r];
    end
    if (p1_v_r && p1_row1_r) begin
      store_up[p1_addr_r] <= mid_rd_r;
    end
  end

  assign top_px = p1_row2_r ? top_rd_r : '0;
  assign mid_px = p1_row1_r ? mid_rd_r : '0;
  assign bot_px = p1_pix_r;

  // Window: entries 0..2 hold the previous column, 3..5 the one before it.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < 6; i++) begin
        win_r[i] <= '0;
      end
    end else if (p1_v_r) begin
      win_r[3] <= win_r[0];
      win_r[4] <= win_r[1];
      win_r[5] <= win_r[2];
      win_r[0] <= top_px;
      win_r[1] <= mid_px;
      win_r[2] <= bot_px;
    end
  end

  always_comb begin
    q_push.valid           = p1_v_r && p1_emit_r;
    q_push.work.dx_sum     = $signed(10'(top_px)) - $signed(10'(win_r[3]))
                           + $signed(10'(bot_px)) - $signed(10'(win_r[5]));
    q_push.work.dx_mid     = $signed(9'(mid_px)) - $signed(9'(win_r[4]));
    q_push.work.dy_sum     = $signed(10'(win_r[5])) + $signed(10'(bot_px))
                           - $signed(10'(win_r[3])) - $signed(10'(top_px));
    q_push.work.dy_mid     = $signed(9'(win_r[2])) - $signed(9'(win_r[0]));
    q_push.work.frame_done = p1_last_r;
  end

endmodule

@@ hw/rtl/scg_queue.sv @@
// Short queue between the front end and the gradient back end.
// Holds window differences; depth and entry type come from scg_pkg.
module scg_queue import scg_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  push_t              q_push,
  input  logic               pop,
  output q_rd_t              q_rd,
  output logic [Q_CNT_W-1:0] q_count
);

  work_t              mem_r [Q_DEPTH];
  logic [Q_PTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [Q_CNT_W-1:0] cnt_r;
  logic               do_pop;

  assign do_pop     = pop && (cnt_r != '0);
  assign q_count    = cnt_r;
  assign q_rd.empty = (cnt_r == '0);
  assign q_rd.head  = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (q_push.valid) begin
        wr_ptr_r <= wr_ptr_r + Q_PTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr_r <= rd_ptr_r + Q_PTR_W'(1);
      end
      cnt_r <= cnt_r + Q_CNT_W'(q_push.valid) - Q_CNT_W'(do_pop);
    end
  end

  always_ff @(posedge clk) begin
    if (q_push.valid) begin
      mem_r[wr_ptr_r] <= q_push.work;
    end
  end

endmodule

@@ hw/rtl/scg_back.sv @@
// Back end: applies the Scharr coefficients to queued differences and
// holds the result in the output register. Uses scg_pkg.
module scg_back import scg_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  q_rd_t       q_rd,
  output logic        pop,
  scg_grad_if.source  out_ch
);

  logic                     out_v_r;
  logic signed [GRAD_W-1:0] gx_r, gy_r, gx, gy;
  logic                     done_r;

  assign pop = !q_rd.empty && (!out_v_r || out_ch.ready);

  assign gx = K_SIDE * GRAD_W'(q_rd.head.dx_sum) + K_MID * GRAD_W'(q_rd.head.dx_mid);
  assign gy = K_SIDE * GRAD_W'(q_rd.head.dy_sum) + K_MID * GRAD_W'(q_rd.head.dy_mid);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (!out_v_r || out_ch.ready) begin
      out_v_r <= !q_rd.empty;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      gx_r   <= gx;
      gy_r   <= gy;
      done_r <= q_rd.head.frame_done;
    end
  end

  assign out_ch.valid      = out_v_r;
  assign out_ch.grad_x     = gx_r;
  assign out_ch.grad_y     = gy_r;
  assign out_ch.frame_done = done_r;

endmodule

@@ hw/rtl/scharr_gradient_3x3.sv @@
// Scharr 3x3 gradient block: the result of a pixel transfer, if it has one, passes the
// read stage and the queue and is valid on the output once the output register is free.
// Throughput is one pixel per clock while the queue has room, set by one read and one
// write of each line store per pixel; a four-entry queue lets the input keep flowing while
// the output stalls. Synchronous active-low reset clears counters, window, queue, output
// register and sets line_width to 640 and frame_height to 480. Line stores are not cleared.
`include "scharr_gradient_3x3_macros.svh"

module scharr_gradient_3x3 import scg_pkg::*; #(
  parameter int MAX_WIDTH = 2048
) (
  input  logic       clk,
  input  logic       rst_n,
  scg_pix_if.sink    in_ch,
  scg_grad_if.source out_ch,
  scg_cfg_if.sink    cfg_ch
);

  localparam int WID_W = $clog2(MAX_WIDTH + 1);
  localparam int W_RST = (WIDTH_RST > MAX_WIDTH) ? MAX_WIDTH : WIDTH_RST;

  logic [WID_W-1:0]   width_r;
  logic [HGT_W-1:0]   height_r;
  logic [31:0]        w_raw, h_raw, w_clamp, h_clamp;
  push_t              q_push;
  q_rd_t              q_rd;
  logic [Q_CNT_W-1:0] q_count;
  logic               pop;

  assign cfg_ch.ready = 1'b1;

  // Registers keep the clamped value, which is all the datapath ever uses.
  assign w_raw   = 32'(cfg_ch.data[LW_REG_W-1:0]);
  assign h_raw   = 32'(cfg_ch.data[FH_REG_W-1:0]);
  assign w_clamp = (w_raw < 32'(MIN_DIM)) ? 32'(MIN_DIM) :
                   (w_raw > 32'(MAX_WIDTH)) ? 32'(MAX_WIDTH) : w_raw;
  assign h_clamp = (h_raw < 32'(MIN_DIM)) ? 32'(MIN_DIM) :
                   (h_raw > 32'(MAX_HEIGHT)) ? 32'(MAX_HEIGHT) : h_raw;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= WID_W'(W_RST);
      height_r <= HGT_W'(HEIGHT_RST);
    end else if (cfg_ch.valid && cfg_ch.ready) begin
      unique case (cfg_ch.index)
        CFG_LINE_WIDTH:   width_r  <= w_clamp[WID_W-1:0];
        CFG_FRAME_HEIGHT: height_r <= h_clamp[HGT_W-1:0];
      endcase
    end
  end

  scg_front #(
    .MAX_WIDTH (MAX_WIDTH)
  ) u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_ch      (in_ch),
    .eff_width  (width_r),
    .eff_height (height_r),
    .q_count    (q_count),
    .q_push     (q_push)
  );

  scg_queue u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .q_push  (q_push),
    .pop     (pop),
    .q_rd    (q_rd),
    .q_count (q_count)
  );

  scg_back u_back (
    .clk    (clk),
    .rst_n  (rst_n),
    .q_rd   (q_rd),
    .pop    (pop),
    .out_ch (out_ch)
  );

  `SCG_ASSERT_SAME(a_push_has_room, clk, rst_n, q_push.valid, q_count != Q_FULL, "push into full queue")
  `SCG_ASSERT_SAME(a_full_stalls_input, clk, rst_n, q_count == Q_FULL, !in_ch.ready, "input open while queue full")
  `SCG_ASSERT_NEXT(a_head_reaches_output, clk, rst_n, !q_rd.empty && !out_ch.valid, out_ch.valid, "queued result not moved to output")

endmodule

@@ tb/sv/tb_scharr_gradient_3x3.sv @@
`timescale 1ns / 1ps
// Self-checking testbench for scharr_gradient_3x3: streams raster frames, predicts the
// gradients of every interior pixel and compares each result transfer with the oldest one.
// Depends on scg_pkg and the scg_pix_if, scg_grad_if and scg_cfg_if interfaces.
module tb_scharr_gradient_3x3 import scg_pkg::*; ();

  localparam int MAX_W    = 2048;
  localparam int SIDE_TAP = 47;
  localparam int MID_TAP  = 162;

  typedef struct packed {
    logic signed [GRAD_W-1:0] gx;
    logic signed [GRAD_W-1:0] gy;
    logic                     done;
  } grad_t;

  typedef enum logic {STEP_CFG, STEP_PIX} step_kind_t;
  typedef enum int {PIX_UNIFORM, PIX_EXTREME, PIX_SMOOTH} pix_mix_t;

  typedef struct packed {
    step_kind_t            kind;
    logic [CFG_IDX_W-1:0]  idx;
    logic [CFG_DATA_W-1:0] val;
    logic                  typed;
    grad_t                 want;
  } dir_step_t;

  // Two 3x3 frames after clamped register writes: a full-scale rising edge across the
  // columns, then a full-scale falling edge down the rows. Each gives one result.
  dir_step_t dir_steps [0:19] = '{
    '{STEP_CFG, CFG_LINE_WIDTH,   13'h1000, 1'b0, '0},
    '{STEP_CFG, CFG_FRAME_HEIGHT, 13'd1,    1'b0, '0},
    '{STEP_PIX, CFG_LINE_WIDTH,   13'd0,    1'b0, '0},
    '{STEP_PIX, CFG_LINE_WIDTH,   13'd128,  1'b0, '0},
    '{STEP_PIX, CFG_LINE_WIDTH,   13'd255,  1'b0, '0},
    '{STEP_PIX, CFG_LINE_WIDTH,   13'd0,    1'b0, '0},
    '{STEP_PIX, CFG_LINE_WIDTH,   13'd128,  1'b0, '0},
    '{STEP_PIX, CFG_LINE_WIDTH,   13'd255,  1'b0, '0},
    '{STEP_PIX, CFG_LINE_WIDTH,   13'd0,    1'b0, '0},
    '{STEP_PIX, CFG_LINE_WIDTH,   13'd128,  1'b0, '0},
    '{STEP_PIX, CFG_LINE_WIDTH,   13'd255,  1'b1, '{17'sd65280, 17'sd0, 1'b1}},
    '{STEP_PIX, CFG_LINE_WIDTH,   13'd255,  1'b0, '0},
    '{STEP_PIX, CFG_LINE_WIDTH,   13'd255,  1'b0, '0},
    '{STEP_PIX, CFG_LINE_WIDTH,   13'd255,  1'b0, '0},
    '{STEP_PIX, CFG_LINE_WIDTH,   13'd7,    1'b0, '0},
    '{STEP_PIX, CFG_LINE_WIDTH,   13'd7,    1'b0, '0},
    '{STEP_PIX, CFG_LINE_WIDTH,   13'd7,    1'b0, '0},
    '{STEP_PIX, CFG_LINE_WIDTH,   13'd0,    1'b0, '0},
    '{STEP_PIX, CFG_LINE_WIDTH,   13'd0,    1'b0, '0},
    '{STEP_PIX, CFG_LINE_WIDTH,   13'd0,    1'b1, '{17'sd0, -17'sd65280, 1'b1}}
  };

  logic clk;
  logic rst_n;

  scg_pix_if  in_ch ();
  scg_grad_if out_ch ();
  scg_cfg_if  cfg_ch ();

  scharr_gradient_3x3 #(.MAX_WIDTH(MAX_W)) dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  // Shadow of the block: registers, line stores, window and raster position.
  logic [LW_REG_W-1:0] line_w_reg  = LW_REG_W'(WIDTH_RST);
  logic [FH_REG_W-1:0] frame_h_reg = FH_REG_W'(HEIGHT_RST);
  logic [PIX_W-1:0]    row_up  [MAX_W] = '{default: '0};
  logic [PIX_W-1:0]    row_mid [MAX_W] = '{default: '0};
  logic [PIX_W-1:0]    win_px  [6]     = '{default: '0};
  int                  pos_col = 0;
  int                  pos_row = 0;

  grad_t pending_grads [$];
  grad_t rx_want;
  int    mismatch_count = 0;
  int    grads_seen = 0;
  int    pixels_sent = 0;
  int    tx_burst_left = 0;
  bit    tx_steady = 1'b0;
  int    rx_mode = 0;
  int    rx_period = 2;
  int    rx_hold = 0;
  int    rx_tick = 0;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic int eff_width();
    if (line_w_reg < MIN_DIM) return MIN_DIM;
    if (line_w_reg > MAX_W) return MAX_W;
    return int'(line_w_reg);
  endfunction

  function automatic int eff_height();
    if (frame_h_reg < MIN_DIM) return MIN_DIM;
    if (frame_h_reg > MAX_HEIGHT) return MAX_HEIGHT;
    return int'(frame_h_reg);
  endfunction

  // Advances the shadow by one pixel; returns 1 when the pixel completes an interior window.
  function automatic bit next_gradient(input logic [PIX_W-1:0] pix, output grad_t g);
    int w, h, c, r, a;
    int top, mid, bot, st, sb, gx, gy;
    bit hit;
    w = eff_width();
    h = eff_height();
    c = pos_col;
    r = pos_row;
    a = (c < MAX_W) ? c : MAX_W - 1;
    bot = int'(pix);
    top = 0;
    mid = 0;
    if (r >= 1) mid = int'(row_mid[a]);
    if (r >= 2) top = int'(row_up[a]);
    hit = (r >= 2 && c >= 2 && c < w && r < h);
    g = '0;
    if (hit) begin
      gx = SIDE_TAP * (top - int'(win_px[3])) + MID_TAP * (mid - int'(win_px[4]))
         + SIDE_TAP * (bot - int'(win_px[5]));
      st = SIDE_TAP * int'(win_px[3]) + MID_TAP * int'(win_px[0]) + SIDE_TAP * top;
      sb = SIDE_TAP * int'(win_px[5]) + MID_TAP * int'(win_px[2]) + SIDE_TAP * bot;
      gy = sb - st;
      g.gx = gx[GRAD_W-1:0];
      g.gy = gy[GRAD_W-1:0];
      g.done = (r == h - 1 && c == w - 1);
    end
    if (r >= 1) row_up[a] = PIX_W'(mid);
    row_mid[a] = pix;
    win_px[3] = win_px[0];
    win_px[4] = win_px[1];
    win_px[5] = win_px[2];
    win_px[0] = PIX_W'(top);
    win_px[1] = PIX_W'(mid);
    win_px[2] = pix;
    if (c + 1 >= w) begin
      pos_col = 0;
      pos_row = (r + 1 >= h) ? 0 : r + 1;
    end else begin
      pos_col = c + 1;
      if (r >= h) pos_row = 0;
    end
    return hit;
  endfunction

  task automatic report_mismatch(input string msg);
    if (mismatch_count < 200) $display("mismatch at %0t: %s", $time, msg);
    mismatch_count++;
  endtask

  task automatic push_pixel(input logic [PIX_W-1:0] pix, input bit typed, input grad_t typed_grad);
    grad_t g;
    if (!tx_steady && tx_burst_left == 0) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk);
      tx_burst_left = $urandom_range(1, 40);
    end
    if (tx_burst_left > 0) tx_burst_left--;
    in_ch.valid <= 1'b1;
    in_ch.pixel <= pix;
    do @(posedge clk); while (!in_ch.ready);
    if (next_gradient(pix, g)) pending_grads.push_back(typed ? typed_grad : g);
    pixels_sent++;
  endtask

  // Holds the input back until every expected result has left, then lets the pipe empty
  // of pixels that cause no result.
  task automatic settle_stream();
    in_ch.valid <= 1'b0;
    while (pending_grads.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    settle_stream();
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= val;
    do @(posedge clk); while (!cfg_ch.ready);
    cfg_ch.valid <= 1'b0;
    if (idx == CFG_LINE_WIDTH) line_w_reg = val[LW_REG_W-1:0];
    else frame_h_reg = val;
  endtask

  // Sends n pixels, then, if asked, keeps going until the raster is back at a frame start.
  task automatic stream_pixels(input int n, input pix_mix_t mix, input bit to_end);
    int sent;
    int base;
    logic [PIX_W-1:0] p;
    sent = 0;
    base = $urandom_range(0, 248);
    while (sent < n || (to_end && !(pos_col == 0 && pos_row == 0))) begin
      case (mix)
        PIX_UNIFORM: p = PIX_W'($urandom_range(0, 255));
        PIX_EXTREME: p = $urandom_range(0, 1) ? 8'hFF : 8'h00;
        default:     p = PIX_W'(base + $urandom_range(0, 7));
      endcase
      push_pixel(p, 1'b0, '0);
      sent++;
    end
  endtask

  always @(posedge clk) begin
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (pending_grads.size() == 0) begin
        report_mismatch($sformatf("result %0d arrived with nothing expected", grads_seen));
      end else begin
        rx_want = pending_grads.pop_front();
        if (out_ch.grad_x !== rx_want.gx)
          report_mismatch($sformatf("result %0d grad_x %0d, expected %0d",
                                    grads_seen, out_ch.grad_x, rx_want.gx));
        if (out_ch.grad_y !== rx_want.gy)
          report_mismatch($sformatf("result %0d grad_y %0d, expected %0d",
                                    grads_seen, out_ch.grad_y, rx_want.gy));
        if (out_ch.frame_done !== rx_want.done)
          report_mismatch($sformatf("result %0d frame_done %b, expected %b",
                                    grads_seen, out_ch.frame_done, rx_want.done));
      end
      grads_seen++;
    end
    // The receiver switches between always ready, random stalls and a sparse periodic ready.
    if (rx_hold == 0) begin
      rx_mode   = $urandom_range(0, 2);
      rx_period = $urandom_range(2, 20);
      rx_hold   = $urandom_range(20, 300);
    end else begin
      rx_hold--;
    end
    rx_tick++;
    case (rx_mode)
      0:       out_ch.ready <= 1'b1;
      1:       out_ch.ready <= ($urandom_range(0, 3) != 0);
      default: out_ch.ready <= (rx_tick % rx_period == 0);
    endcase
  end

  initial begin
    int wv;
    int hv;
    int nfr;
    pix_mix_t mix;
    rst_n        <= 1'b0;
    in_ch.valid  <= 1'b0;
    in_ch.pixel  <= '0;
    cfg_ch.valid <= 1'b0;
    cfg_ch.index <= CFG_LINE_WIDTH;
    cfg_ch.data  <= '0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    foreach (dir_steps[i]) begin
      if (dir_steps[i].kind == STEP_CFG)
        write_reg(dir_steps[i].idx, dir_steps[i].val);
      else
        push_pixel(dir_steps[i].val[PIX_W-1:0], dir_steps[i].typed, dir_steps[i].want);
    end

    // Widest rows: 4095 clamps to the maximum width, which is then lowered mid-row.
    // Tallest frame: 8191 clamps to the maximum height, 4096 is written mid-frame, and a
    // height below the current row then sends the raster back to the frame start.
    write_reg(CFG_LINE_WIDTH, 13'h1FFF);
    write_reg(CFG_FRAME_HEIGHT, 13'd3);
    stream_pixels(40, PIX_UNIFORM, 1'b0);
    write_reg(CFG_LINE_WIDTH, 13'd5);
    stream_pixels(1, PIX_EXTREME, 1'b1);
    write_reg(CFG_LINE_WIDTH, 13'd3);
    write_reg(CFG_FRAME_HEIGHT, 13'h1FFF);
    stream_pixels(90, PIX_SMOOTH, 1'b0);
    write_reg(CFG_FRAME_HEIGHT, 13'h1000);
    stream_pixels(30, PIX_UNIFORM, 1'b0);
    write_reg(CFG_FRAME_HEIGHT, 13'd5);
    stream_pixels(1, PIX_UNIFORM, 1'b1);

    while (pixels_sent < 1350) begin
      tx_steady = ($urandom_range(0, 3) == 0);
      wv = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 2) : $urandom_range(3, 16);
      write_reg(CFG_LINE_WIDTH, {1'($urandom_range(0, 1)), LW_REG_W'(wv)});
      hv = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 2) : $urandom_range(3, 8);
      write_reg(CFG_FRAME_HEIGHT, FH_REG_W'(hv));
      nfr = $urandom_range(1, 3);
      repeat (nfr) begin
        mix = pix_mix_t'($urandom_range(0, 2));
        if ($urandom_range(0, 3) == 0) begin
          stream_pixels($urandom_range(1, eff_width() * eff_height() - 1), mix, 1'b0);
          // The width may only grow in the first row, where every store entry it reaches
          // is written before it is read.
          if ($urandom_range(0, 1))
            write_reg(CFG_FRAME_HEIGHT, FH_REG_W'($urandom_range(0, 10)));
          else
            write_reg(CFG_LINE_WIDTH,
                      CFG_DATA_W'($urandom_range(3, pos_row == 0 ? 16 : eff_width())));
        end
        stream_pixels(1, mix, 1'b1);
      end
    end

    in_ch.valid <= 1'b0;
    for (int k = 0; k < 5000 && pending_grads.size() != 0; k++) @(posedge clk);
    repeat (10) @(posedge clk);
    if (pending_grads.size() != 0)
      report_mismatch($sformatf("%0d expected results never arrived", pending_grads.size()));
    if (mismatch_count == 0) begin
      $display("tb_scharr_gradient_3x3: done, clean");
    end else begin
      $display("tb_scharr_gradient_3x3: done, errors");
    end
    $finish;
  end

  initial begin
    #50ms;
    $display("tb_scharr_gradient_3x3: done, errors");
    $finish;
  end

endmodule

@@ files.f @@
+incdir+hw/rtl
hw/rtl/scg_pkg.sv
hw/rtl/scg_pix_if.sv
hw/rtl/scg_grad_if.sv
hw/rtl/scg_cfg_if.sv
hw/rtl/scg_front.sv
hw/rtl/scg_queue.sv
hw/rtl/scg_back.sv
hw/rtl/scharr_gradient_3x3.sv
tb/sv/tb_scharr_gradient_3x3.sv
